FILE: rtl/dsnp_pkg.sv
// Shared types and constants for the decimal scientific number parser.
`timescale 1ns / 1ps

package dsnp_pkg;

  // Number of mantissa digits kept before further digits are dropped.
  localparam int MANT_DIGITS = 19;
  // Saturation value of the exponent digits and of the dropped-digit count.
  localparam int EXP_LIMIT = 9999;
  // Magnitude bound of the result exponent.
  localparam int EXP_BOUND = (EXP_LIMIT + MANT_DIGITS > 16383) ? 16383
                                                               : EXP_LIMIT + MANT_DIGITS;

  localparam int MANT_W = 64;
  localparam int DEXP_W = 15;

  // ASCII codes the parser looks for.
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_E_LO  = 8'h65;
  localparam logic [7:0] CH_E_UP  = 8'h45;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Parse phases.
  typedef enum logic [2:0] {
    PH_WS    = 3'd0,
    PH_INT   = 3'd1,
    PH_FRAC  = 3'd2,
    PH_ESIGN = 3'd3,
    PH_EDIG  = 3'd4,
    PH_DONE  = 3'd5
  } phase_t;

  // Parser state carried from one item to the next.
  typedef struct packed {
    phase_t      phase;
    logic        sign_flag;
    logic [63:0] mant_acc;
    logic [4:0]  kept_digits;
    logic [4:0]  frac_kept;
    logic [14:0] int_dropped;
    logic [13:0] exp_acc;
    logic        exp_negative;
    logic        trunc_flag;
  } state_t;

  // Result of one string.
  typedef struct packed {
    logic              negative;
    logic [MANT_W-1:0] mantissa;
    logic [DEXP_W-1:0] dec_exponent;
    logic              truncated;
  } result_t;

  localparam state_t STATE_RESET = '{
    phase:        PH_WS,
    sign_flag:    1'b0,
    mant_acc:     64'd0,
    kept_digits:  5'd0,
    frac_kept:    5'd0,
    int_dropped:  15'd0,
    exp_acc:      14'd0,
    exp_negative: 1'b0,
    trunc_flag:   1'b0
  };

endpackage

FILE: rtl/dsnp_char_if.sv
// Handshake channel that carries one character item of the number string.
`timescale 1ns / 1ps

interface dsnp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_string;

  modport source (output valid, output char_code, output end_of_string, input ready);
  modport sink (input valid, input char_code, input end_of_string, output ready);
endinterface

FILE: rtl/dsnp_result_if.sv
// Handshake channel that carries one parsed number item.
`timescale 1ns / 1ps

interface dsnp_result_if;
  logic        valid;
  logic        ready;
  logic        negative;
  logic [63:0] mantissa;
  logic [14:0] dec_exponent;
  logic        truncated;

  modport source (output valid, output negative, output mantissa, output dec_exponent,
                  output truncated, input ready);
  modport sink (input valid, input negative, input mantissa, input dec_exponent,
                input truncated, output ready);
endinterface

FILE: rtl/dsnp_step.sv
// Next-state logic of the parser for one character and the final result of a string.
`timescale 1ns / 1ps

module dsnp_step (
  input  dsnp_pkg::state_t  cur,
  input  logic [7:0]        char_code,
  output dsnp_pkg::state_t  nxt,
  output dsnp_pkg::result_t res
);
  import dsnp_pkg::*;

  localparam logic signed [16:0] BOUND_POS = 17'(EXP_BOUND);
  localparam logic signed [16:0] BOUND_NEG = -17'(EXP_BOUND);

  logic        is_digit;
  logic        is_space;
  logic        is_exp_mark;
  logic        is_sign;
  logic        is_point;
  logic [3:0]  digit;
  logic        mant_room;
  logic [63:0] mant_next;
  logic [17:0] exp_sum;
  logic        exp_sat;
  logic [13:0] exp_next;
  logic signed [16:0] e_mag;
  logic signed [16:0] e_signed;
  logic signed [16:0] e_sum;
  logic signed [16:0] e_clamped;
  logic        e_clip;

  // Character classes.
  assign is_digit    = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign is_space    = (char_code == CH_SPACE) || ((char_code >= CH_TAB) && (char_code <= CH_CR));
  assign is_exp_mark = (char_code == CH_E_LO) || (char_code == CH_E_UP);
  assign is_sign     = (char_code == CH_PLUS) || (char_code == CH_MINUS);
  assign is_point    = (char_code == CH_POINT);
  assign digit       = char_code[3:0];

  // Mantissa accumulate: times ten plus the new digit, as two shifts and adds.
  assign mant_room = cur.kept_digits < 5'(MANT_DIGITS);
  assign mant_next = {cur.mant_acc[60:0], 3'b000} + {cur.mant_acc[62:0], 1'b0}
                   + {60'd0, digit};

  // Exponent accumulate with saturation.
  assign exp_sum  = {1'b0, cur.exp_acc, 3'b000} + {3'b000, cur.exp_acc, 1'b0}
                  + {14'd0, digit};
  assign exp_sat  = exp_sum > 18'(EXP_LIMIT);
  assign exp_next = exp_sat ? 14'(EXP_LIMIT) : exp_sum[13:0];

  // One character applied to the state.
  always_comb begin
    nxt = cur;
    unique case (cur.phase)
      PH_WS: begin
        if (is_space) begin
          nxt.phase = PH_WS;
        end else if (is_sign) begin
          nxt.sign_flag = (char_code == CH_MINUS);
          nxt.phase     = PH_INT;
        end else if (is_digit) begin
          nxt.phase = PH_INT;
          if (mant_room) begin
            nxt.mant_acc    = mant_next;
            nxt.kept_digits = cur.kept_digits + 5'd1;
          end else begin
            nxt.trunc_flag = 1'b1;
            if (cur.int_dropped < 15'(EXP_LIMIT)) begin
              nxt.int_dropped = cur.int_dropped + 15'd1;
            end
          end
        end else if (is_point) begin
          nxt.phase = PH_FRAC;
        end else if (is_exp_mark) begin
          nxt.phase = PH_ESIGN;
        end else begin
          nxt.phase = PH_DONE;
        end
      end
      PH_INT: begin
        if (is_digit) begin
          if (mant_room) begin
            nxt.mant_acc    = mant_next;
            nxt.kept_digits = cur.kept_digits + 5'd1;
          end else begin
            nxt.trunc_flag = 1'b1;
            if (cur.int_dropped < 15'(EXP_LIMIT)) begin
              nxt.int_dropped = cur.int_dropped + 15'd1;
            end
          end
        end else if (is_point) begin
          nxt.phase = PH_FRAC;
        end else if (is_exp_mark) begin
          nxt.phase = PH_ESIGN;
        end else begin
          nxt.phase = PH_DONE;
        end
      end
      PH_FRAC: begin
        if (is_digit) begin
          if (mant_room) begin
            nxt.mant_acc    = mant_next;
            nxt.kept_digits = cur.kept_digits + 5'd1;
            nxt.frac_kept   = cur.frac_kept + 5'd1;
          end else begin
            nxt.trunc_flag = 1'b1;
          end
        end else if (is_exp_mark) begin
          nxt.phase = PH_ESIGN;
        end else begin
          nxt.phase = PH_DONE;
        end
      end
      PH_ESIGN: begin
        if (is_sign) begin
          nxt.exp_negative = (char_code == CH_MINUS);
          nxt.phase        = PH_EDIG;
        end else if (is_digit) begin
          nxt.exp_acc    = exp_next;
          nxt.trunc_flag = cur.trunc_flag | exp_sat;
          nxt.phase      = PH_EDIG;
        end else begin
          nxt.phase = PH_DONE;
        end
      end
      PH_EDIG: begin
        if (is_digit) begin
          nxt.exp_acc    = exp_next;
          nxt.trunc_flag = cur.trunc_flag | exp_sat;
        end else begin
          nxt.phase = PH_DONE;
        end
      end
      default: begin
        nxt.phase = PH_DONE;
      end
    endcase
  end

  // Result exponent: signed exponent less fraction digits plus dropped digits, clamped.
  assign e_mag    = $signed({3'b000, cur.exp_acc});
  assign e_signed = cur.exp_negative ? -e_mag : e_mag;
  assign e_sum    = e_signed - $signed({12'd0, cur.frac_kept}) + $signed({2'b00, cur.int_dropped});

  always_comb begin
    e_clamped = e_sum;
    e_clip    = 1'b0;
    if (e_sum > BOUND_POS) begin
      e_clamped = BOUND_POS;
      e_clip    = 1'b1;
    end else if (e_sum < BOUND_NEG) begin
      e_clamped = BOUND_NEG;
      e_clip    = 1'b1;
    end
  end

  assign res.negative     = cur.sign_flag;
  assign res.mantissa     = cur.mant_acc;
  assign res.dec_exponent = e_clamped[DEXP_W-1:0];
  assign res.truncated    = cur.trunc_flag | e_clip;

endmodule

FILE: rtl/decimal_scientific_number_parser_unit.sv
// Top level of the decimal scientific number parser: input stage, parser state, result register.
//
// The chars channel carries a number string one character item at a time; an item
// with end_of_string set closes the string, and its char_code is ignored. For each
// end item the results channel delivers one item: the sign, the kept decimal digits
// as an unsigned mantissa, the power-of-ten exponent and a truncation flag. Character
// items produce no result. After an end item the parser starts over for the next string.
// Every item is registered in an input stage at acceptance and applied to the parser
// state when it moves on from there. A result is registered in the output register
// when its end item moves on, and stays until it is taken.
// Throughput is one item per cycle unless an end item waits for the output register; each
// character takes the single multiply-by-ten-and-add step from input stage to state registers.
// When the receiver stalls, character items keep flowing; an end item waits in the
// input stage while an untaken result occupies the output register, and chars.ready
// then drops until the result is taken.
// A synchronous reset empties both registers and returns the parser to the
// leading white space phase; chars.ready is high in the cycle after reset.
`timescale 1ns / 1ps

module decimal_scientific_number_parser_unit (
  input logic          clk,
  input logic          rst,
  dsnp_char_if.sink    chars,
  dsnp_result_if.source results
);
  import dsnp_pkg::*;

  logic       stage_valid;
  logic [7:0] stage_char;
  logic       stage_eos;
  state_t     state;
  state_t     state_next;
  result_t    res_next;
  result_t    res;
  logic       out_valid;
  logic       out_free;
  logic       stage_fire;

  dsnp_step u_step (
    .cur       (state),
    .char_code (stage_char),
    .nxt       (state_next),
    .res       (res_next)
  );

  // Handshake: an end item may move on only if the output register is free.
  assign out_free   = !out_valid || results.ready;
  assign stage_fire = stage_valid && (!stage_eos || out_free);
  assign chars.ready = !stage_valid || stage_fire;

  // Control registers and parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
      state       <= STATE_RESET;
    end else begin
      if (chars.ready) begin
        stage_valid <= chars.valid;
      end
      if (stage_fire) begin
        state <= stage_eos ? STATE_RESET : state_next;
      end
      if (stage_fire && stage_eos) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      stage_char <= chars.char_code;
      stage_eos  <= chars.end_of_string;
    end
    if (stage_fire && stage_eos) begin
      res <= res_next;
    end
  end

  assign results.valid        = out_valid;
  assign results.negative     = res.negative;
  assign results.mantissa     = res.mantissa;
  assign results.dec_exponent = res.dec_exponent;
  assign results.truncated    = res.truncated;

  // An end item that moves on leaves the parser in its reset state.
  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    stage_fire && stage_eos |=> state == STATE_RESET)
    else $error("parser state not cleared after an end item");

  // An end item must not pass while an untaken result sits in the output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    stage_valid && stage_eos && out_valid && !results.ready |-> !chars.ready && !stage_fire)
    else $error("result register would be overwritten");

  // The digit counters stay within the kept-digit budget.
  a_digit_budget: assert property (@(posedge clk) disable iff (rst)
    state.kept_digits <= 5'(MANT_DIGITS) && state.frac_kept <= state.kept_digits)
    else $error("digit counters out of range");

  // Exponent accumulator and dropped-digit count saturate.
  a_exp_sat: assert property (@(posedge clk) disable iff (rst)
    state.exp_acc <= 14'(EXP_LIMIT) && state.int_dropped <= 15'(EXP_LIMIT))
    else $error("exponent counters above saturation value");

  // A result appears only in the cycle after an end item moves on.
  a_result_timing: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(stage_fire && stage_eos))
    else $error("result shown without an end item");

endmodule
